// ===== rtl/bmpup_pkg.sv =====
// Shared types and constants of the pixel replication upscaler.
package bmpup_pkg;

  // Line store geometry.
  localparam int LINE_PIXELS = 1024;
  localparam int ADDR_W      = $clog2(LINE_PIXELS);

  // Field and register widths.
  localparam int SCALE_W   = 7;
  localparam int WIDTH_W   = 11;
  localparam int CHAN_W    = 8;
  localparam int PIXEL_W   = 3 * CHAN_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 11;
  localparam int PAD_W     = 2;

  // Clamp limits for the configuration registers.
  localparam logic [SCALE_W-1:0] MAX_SCALE = SCALE_W'(100);
  localparam logic [WIDTH_W-1:0] MAX_WIDTH = WIDTH_W'(LINE_PIXELS);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 1'b1;

  // Input word actions.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Result word kinds.
  typedef enum logic [2:0] {
    KIND_PIXEL   = 3'd0,
    KIND_PAD     = 3'd1,
    KIND_IDLE    = 3'd2,
    KIND_LOADED  = 3'd3,
    KIND_REFUSED = 3'd4
  } kind_t;

endpackage

// ===== rtl/bmp_pixel_replication_upscaler.sv =====
// A result word is registered and presented the cycle after its input word is taken.
// Throughput: one word per cycle; in_stall rises only while a result is held by out_stall.
// The line store is a 1024 x 24 synchronous RAM whose read register loads together with the output register.
// Reset clears all counters and the output valid flag, and sets both config registers to 1.
// The line store is not cleared; entries are defined once loaded, so no clearing pass runs.
// Top level of the pixel replication upscaler.
module bmp_pixel_replication_upscaler
  import bmpup_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write port.
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // Input channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 action,
  input  logic [CHAN_W-1:0]    blue_in,
  input  logic [CHAN_W-1:0]    green_in,
  input  logic [CHAN_W-1:0]    red_in,
  // Output channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           kind,
  output logic [CHAN_W-1:0]    blue_out,
  output logic [CHAN_W-1:0]    green_out,
  output logic [CHAN_W-1:0]    red_out,
  output logic                 row_end,
  output logic                 group_end
);

  // Configuration registers.
  logic [SCALE_W-1:0] scale_factor;
  logic [WIDTH_W-1:0] source_width;

  // Control state.
  logic [WIDTH_W-1:0] load_count,   load_count_next;
  logic               emitting,     emitting_next;
  logic [ADDR_W-1:0]  read_index,   read_index_next;
  logic [SCALE_W-1:0] horiz_repeat, horiz_repeat_next;
  logic [SCALE_W-1:0] vert_repeat,  vert_repeat_next;
  logic [PAD_W-1:0]   pad_count,    pad_count_next;

  // Line store and its registered read port.
  logic [PIXEL_W-1:0] line_store [LINE_PIXELS];
  logic [PIXEL_W-1:0] rd_data;

  // Output register.
  kind_t              out_kind, res_kind;
  logic               out_row,  res_row;
  logic               out_group, res_group;

  logic               in_accept;
  logic               wr_en, rd_en;
  logic [SCALE_W-1:0] eff_scale;
  logic [WIDTH_W-1:0] eff_width;
  logic [WIDTH_W:0]   lc_inc;
  logic [WIDTH_W-1:0] ri_inc;
  logic [SCALE_W:0]   hr_inc;
  logic [SCALE_W:0]   vr_inc;
  logic [PAD_W-1:0]   pad_prod;
  logic               row_done;

  // The input side waits only while a finished word is held downstream.
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= SCALE_W'(1);
      source_width <= WIDTH_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SCALE: scale_factor <= cfg_data[SCALE_W-1:0];
        CFG_WIDTH: source_width <= cfg_data[WIDTH_W-1:0];
        default:   ;
      endcase
    end
  end

  // Clamp the registers into their meaningful ranges.
  always_comb begin
    if (scale_factor == '0)          eff_scale = SCALE_W'(1);
    else if (scale_factor > MAX_SCALE) eff_scale = MAX_SCALE;
    else                             eff_scale = scale_factor;
    if (source_width == '0)          eff_width = WIDTH_W'(1);
    else if (source_width > MAX_WIDTH) eff_width = MAX_WIDTH;
    else                             eff_width = source_width;
  end

  // Counter increments and the pad byte count of one output row.
  assign lc_inc   = {1'b0, load_count} + (WIDTH_W+1)'(1);
  assign ri_inc   = {1'b0, read_index} + WIDTH_W'(1);
  assign hr_inc   = {1'b0, horiz_repeat} + (SCALE_W+1)'(1);
  assign vr_inc   = {1'b0, vert_repeat} + (SCALE_W+1)'(1);
  assign pad_prod = eff_width[1:0] * eff_scale[1:0];

  // Next state and result of the current input word.
  always_comb begin
    load_count_next   = load_count;
    emitting_next     = emitting;
    read_index_next   = read_index;
    horiz_repeat_next = horiz_repeat;
    vert_repeat_next  = vert_repeat;
    pad_count_next    = pad_count;
    wr_en             = 1'b0;
    rd_en             = 1'b0;
    row_done          = 1'b0;
    res_kind          = KIND_IDLE;
    res_row           = 1'b0;
    res_group         = 1'b0;

    if (action == ACT_LOAD) begin
      if (emitting) begin
        res_kind = KIND_REFUSED;
      end else begin
        res_kind = KIND_LOADED;
        wr_en    = !load_count[WIDTH_W-1];
        if (lc_inc >= {1'b0, eff_width}) begin
          load_count_next   = '0;
          emitting_next     = 1'b1;
          read_index_next   = '0;
          horiz_repeat_next = '0;
          vert_repeat_next  = '0;
          pad_count_next    = '0;
        end else begin
          load_count_next = lc_inc[WIDTH_W-1:0];
        end
      end
    end else if (emitting) begin
      if (pad_count != '0) begin
        // Trailing zero bytes that round the row up to a multiple of four bytes.
        res_kind       = KIND_PAD;
        pad_count_next = pad_count - PAD_W'(1);
        row_done       = (pad_count == PAD_W'(1));
      end else begin
        // Replicated pixel; its bytes arrive from the store next cycle.
        res_kind = KIND_PIXEL;
        rd_en    = 1'b1;
        if (hr_inc >= {1'b0, eff_scale}) begin
          horiz_repeat_next = '0;
          if (ri_inc >= eff_width) begin
            read_index_next = '0;
            if (pad_prod == '0) row_done = 1'b1;
            else                pad_count_next = pad_prod;
          end else begin
            read_index_next = ri_inc[ADDR_W-1:0];
          end
        end else begin
          horiz_repeat_next = hr_inc[SCALE_W-1:0];
        end
      end

      // End of an output row; the last repeat frees the store.
      if (row_done) begin
        res_row = 1'b1;
        if (vr_inc >= {1'b0, eff_scale}) begin
          vert_repeat_next = '0;
          emitting_next    = 1'b0;
          res_group        = 1'b1;
        end else begin
          vert_repeat_next = vr_inc[SCALE_W-1:0];
        end
      end
    end
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count   <= '0;
      emitting     <= 1'b0;
      read_index   <= '0;
      horiz_repeat <= '0;
      vert_repeat  <= '0;
      pad_count    <= '0;
    end else if (in_accept) begin
      load_count   <= load_count_next;
      emitting     <= emitting_next;
      read_index   <= read_index_next;
      horiz_repeat <= horiz_repeat_next;
      vert_repeat  <= vert_repeat_next;
      pad_count    <= pad_count_next;
    end
  end

  // Line store write port; loads and pixel reads never share a cycle.
  always_ff @(posedge clk) begin
    if (in_accept && wr_en) begin
      line_store[load_count[ADDR_W-1:0]] <= {red_in, green_in, blue_in};
    end
  end

  // Line store read port; the data holds while the output is stalled.
  always_ff @(posedge clk) begin
    if (in_accept && rd_en) begin
      rd_data <= line_store[read_index];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_kind  <= res_kind;
      out_row   <= res_row;
      out_group <= res_group;
    end
  end

  // Pixel bytes come straight from the store read register.
  assign kind      = out_kind;
  assign row_end   = out_row;
  assign group_end = out_group;
  assign blue_out  = (out_kind == KIND_PIXEL) ? rd_data[CHAN_W-1:0]          : '0;
  assign green_out = (out_kind == KIND_PIXEL) ? rd_data[2*CHAN_W-1:CHAN_W]   : '0;
  assign red_out   = (out_kind == KIND_PIXEL) ? rd_data[3*CHAN_W-1:2*CHAN_W] : '0;

endmodule

// ===== rtl/bmpup_checker.sv =====
// Port-level assertions for the pixel replication upscaler, bound to its top level.
module bmpup_checker
  import bmpup_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [2:0]        kind,
  input logic [CHAN_W-1:0] blue_out,
  input logic [CHAN_W-1:0] green_out,
  input logic [CHAN_W-1:0] red_out,
  input logic              row_end,
  input logic              group_end
);

  // A held result word keeps its kind, its blue byte and its end flags.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(blue_out) &&
      $stable(row_end) && $stable(group_end))
    else $error("held output word changed");

  // Only pixel words carry color bytes.
  a_zero_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_PIXEL |-> blue_out == '0 && green_out == '0 && red_out == '0)
    else $error("non-pixel word carries color bytes");

  // The end of a group is always the end of a row.
  a_group_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && group_end |-> row_end)
    else $error("group end without row end");

  // Rows end only on a pixel or a pad byte.
  a_row_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && row_end |-> kind == KIND_PIXEL || kind == KIND_PAD)
    else $error("row end on a word that is neither pixel nor pad");

  // The input waits only behind a held result word.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held output word");

endmodule

bind bmp_pixel_replication_upscaler bmpup_checker u_bmpup_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .kind      (kind),
  .blue_out  (blue_out),
  .green_out (green_out),
  .red_out   (red_out),
  .row_end   (row_end),
  .group_end (group_end)
);

// ===== tb/sv/bmp_pixel_replication_upscaler_test.sv =====
// Self-checking testbench for the pixel replication upscaler.
module bmp_pixel_replication_upscaler_test;
  import bmpup_pkg::*;

  // One result word as the block presents it.
  typedef struct {
    kind_t             kind;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic              row_end;
    logic              group_end;
  } upscale_word_t;

  localparam int QUIET_LIMIT = 5000;
  localparam int MAX_REPORTS = 40;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SCALE;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 action = ACT_LOAD;
  logic [CHAN_W-1:0]    blue_in = '0;
  logic [CHAN_W-1:0]    green_in = '0;
  logic [CHAN_W-1:0]    red_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           kind;
  logic [CHAN_W-1:0]    blue_out;
  logic [CHAN_W-1:0]    green_out;
  logic [CHAN_W-1:0]    red_out;
  logic                 row_end;
  logic                 group_end;

  bmp_pixel_replication_upscaler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .blue_in   (blue_in),
    .green_in  (green_in),
    .red_in    (red_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .blue_out  (blue_out),
    .green_out (green_out),
    .red_out   (red_out),
    .row_end   (row_end),
    .group_end (group_end)
  );

  // Shadow copy of the upscaler state and its two registers.
  logic [PIXEL_W-1:0] src_line [0:LINE_PIXELS-1];
  logic [WIDTH_W-1:0] fill_pos = '0;
  logic               emit_on = 1'b0;
  logic [ADDR_W-1:0]  rd_pos = '0;
  logic [SCALE_W-1:0] hrep = '0;
  logic [SCALE_W-1:0] vrep = '0;
  logic [PAD_W-1:0]   pads_left = '0;
  logic [SCALE_W-1:0] scale_reg = SCALE_W'(1);
  logic [WIDTH_W-1:0] width_reg = WIDTH_W'(1);

  // Expected result words, oldest first, and run statistics.
  upscale_word_t pending_words [$];
  int words_sent = 0;
  int words_checked = 0;
  int groups_seen = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  // Knobs for the sender gaps and the receiver stalls.
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Computes the result word for one input word and advances the shadow state.
  function automatic upscale_word_t upscale_next(input logic act, input logic [PIXEL_W-1:0] px);
    upscale_word_t res;
    int            s;
    int            wd;
    int            pads;
    logic          row_done;
    res = '{KIND_IDLE, '0, '0, '0, 1'b0, 1'b0};
    row_done = 1'b0;
    s = (scale_reg == 0) ? 1 : ((scale_reg > MAX_SCALE) ? int'(MAX_SCALE) : int'(scale_reg));
    wd = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? LINE_PIXELS : int'(width_reg));
    if (act == ACT_LOAD) begin
      if (emit_on) begin
        res.kind = KIND_REFUSED;
        return res;
      end
      src_line[fill_pos[ADDR_W-1:0]] = px;
      if (int'(fill_pos) + 1 >= wd) begin
        fill_pos = '0;
        emit_on = 1'b1;
        rd_pos = '0;
        hrep = '0;
        vrep = '0;
        pads_left = '0;
      end else begin
        fill_pos = fill_pos + WIDTH_W'(1);
      end
      res.kind = KIND_LOADED;
      return res;
    end
    if (!emit_on) begin
      return res;
    end
    if (pads_left != 0) begin
      // Zero pad bytes close the row once the last one is out.
      pads_left = pads_left - PAD_W'(1);
      row_done = (pads_left == 0);
      res.kind = KIND_PAD;
    end else begin
      res.kind = KIND_PIXEL;
      {res.red, res.green, res.blue} = src_line[rd_pos];
      if (int'(hrep) + 1 >= s) begin
        hrep = '0;
        if (int'(rd_pos) + 1 >= wd) begin
          pads = (wd * s) % 4;
          rd_pos = '0;
          if (pads == 0) begin
            row_done = 1'b1;
          end else begin
            pads_left = PAD_W'(pads);
          end
        end else begin
          rd_pos = rd_pos + ADDR_W'(1);
        end
      end else begin
        hrep = hrep + SCALE_W'(1);
      end
    end
    // The group ends when the row has been repeated scale times.
    if (row_done) begin
      vrep = vrep + SCALE_W'(1);
      if (int'(vrep) >= s) begin
        vrep = '0;
        emit_on = 1'b0;
        res.group_end = 1'b1;
      end
    end
    res.row_end = row_done;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_REPORTS) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
    fail_count++;
  endtask

  // Offers one input word, with random idle gaps, and waits until it is taken.
  task automatic send_word(input logic act, input logic [PIXEL_W-1:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    {red_in, green_in, blue_in} <= px;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_words.push_back(upscale_next(act, px));
    words_sent++;
  endtask

  // Stops offering words and waits until every expected word has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  // Register writes only happen with nothing in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    drain_results();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_SCALE) begin
      scale_reg = value[SCALE_W-1:0];
    end else begin
      width_reg = value[WIDTH_W-1:0];
    end
    @(posedge clk);
  endtask

  task automatic send_tick();
    send_word(ACT_TICK, PIXEL_W'($urandom));
  endtask

  // Ticks until the current row group has been sent out completely.
  task automatic finish_group();
    while (emit_on) begin
      send_tick();
    end
  endtask

  // Loads one full source row and emits its group, mixing in stray words.
  task automatic send_row(input int noise_pct);
    while (!emit_on) begin
      if ($urandom_range(99) < noise_pct) begin
        send_tick();
      end else begin
        send_word(ACT_LOAD, PIXEL_W'($urandom));
      end
    end
    while (emit_on) begin
      if ($urandom_range(99) < noise_pct) begin
        send_word(ACT_LOAD, PIXEL_W'($urandom));
      end else begin
        send_tick();
      end
    end
  endtask

  // Default registers: idle tick, one-pixel row with one pad byte, refused load.
  task automatic test_power_up();
    send_tick();
    send_word(ACT_LOAD, 24'hFF00FF);
    send_word(ACT_LOAD, 24'h123456);
    send_tick();
    send_tick();
    send_tick();
  endtask

  // Zero registers act as one; extreme pixel bytes pass through unchanged.
  task automatic test_register_clamps();
    write_reg(CFG_SCALE, '0);
    write_reg(CFG_WIDTH, '0);
    send_word(ACT_LOAD, 24'h00FF00);
    finish_group();
    write_reg(CFG_SCALE, CFG_W'(2));
    write_reg(CFG_WIDTH, CFG_W'(2));
    send_word(ACT_LOAD, 24'h000000);
    send_tick();
    send_word(ACT_LOAD, 24'hFFFFFF);
    finish_group();
    send_tick();
  endtask

  // A scale above the ceiling runs at 100, then a drop to one ends the group.
  task automatic test_scale_ceiling();
    write_reg(CFG_WIDTH, CFG_W'(1));
    write_reg(CFG_SCALE, CFG_W'(127));
    send_word(ACT_LOAD, PIXEL_W'($urandom));
    repeat (105) send_tick();
    write_reg(CFG_SCALE, CFG_W'(1));
    finish_group();
  endtask

  // Fills the whole line store; a width above the store acts as the store size.
  task automatic test_full_line();
    send_idle_pct = 20;
    stall_pct = 20;
    write_reg(CFG_SCALE, CFG_W'(1));
    write_reg(CFG_WIDTH, CFG_W'(LINE_PIXELS));
    repeat (LINE_PIXELS) send_word(ACT_LOAD, PIXEL_W'($urandom));
    send_word(ACT_LOAD, PIXEL_W'($urandom));
    repeat (12) send_tick();
    write_reg(CFG_WIDTH, CFG_W'(2047));
    repeat (4) send_tick();
    write_reg(CFG_WIDTH, CFG_W'(20));
    finish_group();
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  // Scale and width change while a row is being sent and act at once.
  task automatic test_mid_row_update();
    write_reg(CFG_SCALE, CFG_W'(3));
    write_reg(CFG_WIDTH, CFG_W'(5));
    repeat (5) send_word(ACT_LOAD, PIXEL_W'($urandom));
    repeat (7) send_tick();
    write_reg(CFG_SCALE, CFG_W'(2));
    repeat (4) send_tick();
    write_reg(CFG_WIDTH, CFG_W'(3));
    finish_group();
  endtask

  // The receiver holds off for a long time while words keep coming.
  task automatic test_backpressure();
    write_reg(CFG_SCALE, CFG_W'(2));
    write_reg(CFG_WIDTH, CFG_W'(3));
    hold_left = 250;
    send_row(0);
    repeat (20) send_tick();
    drain_results();
  endtask

  // Random rows under each mix of sender gaps and receiver stalls.
  task automatic test_random_rows();
    int idle_mix [4] = '{0, 70, 0, 8};
    int stall_mix [4] = '{0, 0, 70, 8};
    int start;
    int s;
    int wv;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_mix[ph];
      stall_pct = stall_mix[ph];
      start = words_sent;
      while (words_sent - start < 25) begin
        if ($urandom_range(1) == 0) begin
          if ($urandom_range(9) == 0) begin
            s = $urandom_range(4, 6);
            wv = $urandom_range(1, 2);
          end else begin
            s = $urandom_range(0, 3);
            wv = $urandom_range(0, 7);
          end
          write_reg(CFG_SCALE, {4'($urandom), 7'(s)});
          write_reg(CFG_WIDTH, CFG_W'(wv));
        end
        send_row($urandom_range(0, 15));
      end
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  // Receiver stalls: a long hold-off when requested, otherwise random.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compares each result word taken with the oldest expected word.
  always @(posedge clk) begin
    upscale_word_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      words_checked++;
      if (group_end === 1'b1) begin
        groups_seen++;
      end
      if (pending_words.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = pending_words.pop_front();
        if (kind !== want.kind) begin
          report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
        end
        if (blue_out !== want.blue) begin
          report_mismatch($sformatf("blue_out %h, expected %h", blue_out, want.blue));
        end
        if (green_out !== want.green) begin
          report_mismatch($sformatf("green_out %h, expected %h", green_out, want.green));
        end
        if (red_out !== want.red) begin
          report_mismatch($sformatf("red_out %h, expected %h", red_out, want.red));
        end
        if (row_end !== want.row_end) begin
          report_mismatch($sformatf("row_end %b, expected %b", row_end, want.row_end));
        end
        if (group_end !== want.group_end) begin
          report_mismatch($sformatf("group_end %b, expected %b", group_end, want.group_end));
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either side ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("bmp_pixel_replication_upscaler_test NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_power_up();
    test_register_clamps();
    test_scale_ceiling();
    test_full_line();
    test_mid_row_update();
    test_backpressure();
    test_random_rows();
    drain_results();
    repeat (6) @(posedge clk);
    $display("Sent %0d input words, checked %0d result words, %0d row groups completed.",
             words_sent, words_checked, groups_seen);
    $display("Covered register clamps, mid-row updates, a full line and a long hold-off.");
    if (fail_count == 0) begin
      $display("bmp_pixel_replication_upscaler_test OK");
    end else begin
      $display("bmp_pixel_replication_upscaler_test NOT OK");
    end
    $finish;
  end

endmodule
